>>> sv/gcm_pkg.sv
// Shared types, constants and codes for the gradient color map.
package gcm_pkg;

  localparam int MAX_STOPS = 16;
  localparam int IDX_W = $clog2(MAX_STOPS);
  localparam int CNT_W = $clog2(MAX_STOPS + 1);
  localparam int POS_W = 17;
  localparam int COL_W = 24;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] colour;
  } stop_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR0,
    S_LK_LAST,
    S_LK_HEAD,
    S_LK_WALK,
    S_LK_GO,
    S_LK_WAIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_SUM,
    L_DIV
  } lerp_state_t;

endpackage

>>> sv/gcm_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module gcm_ram #(
  parameter int DW = 41,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/gcm_lerp.sv
// One color channel lane: weighted sum of two endpoints, then 8-step floor division.
module gcm_lerp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [7:0]               c0,
  input  logic [7:0]               c1,
  input  logic [gcm_pkg::POS_W-1:0] w0,
  input  logic [gcm_pkg::POS_W-1:0] w1,
  input  logic [gcm_pkg::POS_W-1:0] span,
  output logic                     done,
  output logic [7:0]               q
);
  import gcm_pkg::*;

  lerp_state_t       state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [24:0]       prod0_r, prod0_nxt;
  logic [24:0]       prod1_r, prod1_nxt;
  logic [POS_W-1:0]  span_r, span_nxt;
  logic [POS_W-1:0]  rem_r, rem_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [7:0]        q_r, q_nxt;
  logic [25:0]       num;
  logic [POS_W:0]    trial;
  logic [POS_W:0]    diff;
  logic              ge;

  assign num   = {1'b0, prod0_r} + {1'b0, prod1_r};
  assign trial = {rem_r, low_r[7]};
  assign ge    = trial >= {1'b0, span_r};
  assign diff  = trial - {1'b0, span_r};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    prod0_nxt = prod0_r;
    prod1_nxt = prod1_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    q_nxt     = q_r;
    unique case (state_r)
      L_IDLE: begin
        if (go) begin
          prod0_nxt = {17'd0, c0} * {8'd0, w0};
          prod1_nxt = {17'd0, c1} * {8'd0, w1};
          span_nxt  = span;
          state_nxt = L_SUM;
        end
      end
      L_SUM: begin
        // quotient is below 256, so the upper 16 bits start below span
        rem_nxt   = {1'b0, num[23:8]};
        low_nxt   = num[7:0];
        step_nxt  = '0;
        state_nxt = L_DIV;
      end
      L_DIV: begin
        rem_nxt  = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
        q_nxt    = {q_r[6:0], ge};
        low_nxt  = {low_r[6:0], 1'b0};
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    prod0_r <= prod0_nxt;
    prod1_r <= prod1_nxt;
    span_r  <= span_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    q_r     <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == L_DIV |-> rem_r < span_r)
    else $error("division remainder not below divisor");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == L_DIV && step_r == 3'd7 |=> done_r && state_r == L_IDLE)
    else $error("division did not finish after eight steps");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == L_DIV)
    else $error("done without a division step");

endmodule

>>> sv/gradient_colour_map.sv
// Top level: sorted color stop table in RAM, insert and lookup sequencer, three lerp lanes.
// Latency: clear, full insert, empty lookup and unused codes strobe a result 1 cycle after start.
// Insert: direct write into an empty table, else larger stops shift up, one RAM read each.
// Lookup: ends return an end stop's colour, else walk one stop per cycle and interpolate.
// Throughput: one word at a time; busy is high until the cycle its result is strobed.
// Reset: synchronous, active low; empties the table, RAM contents are not cleared.
module gradient_colour_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [16:0] in_stop_position,
  input  logic [7:0]  in_stop_red,
  input  logic [7:0]  in_stop_green,
  input  logic [7:0]  in_stop_blue,
  input  logic [16:0] in_factor,
  output logic        out_strobe,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [1:0]  out_status
);
  import gcm_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              strobe_r, strobe_nxt;
  logic [COL_W-1:0]  rgb_r, rgb_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [POS_W-1:0]  f_r, f_nxt;
  stop_t             new_r, new_nxt;
  stop_t             prev_r, prev_nxt;
  logic [POS_W-1:0]  w0_r, w0_nxt;
  logic [POS_W-1:0]  w1_r, w1_nxt;
  logic [POS_W-1:0]  span_r, span_nxt;
  logic [COL_W-1:0]  c1_r, c1_nxt;

  stop_t             new_in;
  stop_t             rd;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_p1;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  stop_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic              lerp_go;
  logic [2:0]        lerp_done;
  logic [7:0]        lerp_q [3];

  assign new_in.pos    = (in_stop_position > POS_ONE) ? POS_ONE : in_stop_position;
  assign new_in.colour = {in_stop_red, in_stop_green, in_stop_blue};
  assign cnt_m1        = count_r - CNT_W'(1);
  assign cnt_p1        = count_r + CNT_W'(1);

  gcm_ram #(
    .DW($bits(stop_t)),
    .AW(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    gcm_lerp u_lerp (
      .clk  (clk),
      .rst_n(rst_n),
      .go   (lerp_go),
      .c0   (prev_r.colour[8*g +: 8]),
      .c1   (c1_r[8*g +: 8]),
      .w0   (w0_r),
      .w1   (w1_r),
      .span (span_r),
      .done (lerp_done[g]),
      .q    (lerp_q[g])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    rgb_nxt    = rgb_r;
    status_nxt = status_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    f_nxt      = f_r;
    new_nxt    = new_r;
    prev_nxt   = prev_r;
    w0_nxt     = w0_r;
    w1_nxt     = w1_r;
    span_nxt   = span_r;
    c1_nxt     = c1_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = new_r;
    ram_raddr  = '0;
    lerp_go    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        f_nxt   = in_factor;
        new_nxt = new_in;
        if (start) begin
          strobe_nxt = 1'b1;
          rgb_nxt    = '0;
          status_nxt = ST_OK;
          unique case (in_operation)
            OP_CLEAR: count_nxt = '0;
            OP_INSERT: begin
              if (count_r == CNT_W'(MAX_STOPS)) begin
                status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_wdata = new_in;
                count_nxt = cnt_p1;
              end else begin
                strobe_nxt = 1'b0;
                j_nxt      = count_r[IDX_W-1:0];
                ram_raddr  = cnt_m1[IDX_W-1:0];
                state_nxt  = S_INS_CMP;
              end
            end
            OP_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                strobe_nxt = 1'b0;
                ram_raddr  = cnt_m1[IDX_W-1:0];
                state_nxt  = S_LK_LAST;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        if (rd.pos > new_r.pos) begin
          ram_wdata = rd;
          if (j_r == IDX_W'(1)) begin
            state_nxt = S_INS_WR0;
          end else begin
            ram_raddr = j_r - IDX_W'(2);
            j_nxt     = j_r - IDX_W'(1);
          end
        end else begin
          count_nxt  = cnt_p1;
          strobe_nxt = 1'b1;
          rgb_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      S_INS_WR0: begin
        ram_we     = 1'b1;
        count_nxt  = cnt_p1;
        strobe_nxt = 1'b1;
        rgb_nxt    = '0;
        status_nxt = ST_OK;
        state_nxt  = S_IDLE;
      end
      S_LK_LAST: begin
        if (f_r >= rd.pos) begin
          // first stop still wins when every stop sits at f
          c1_nxt    = rd.colour;
          state_nxt = S_LK_HEAD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_LK_WALK;
        end
      end
      S_LK_HEAD: begin
        strobe_nxt = 1'b1;
        rgb_nxt    = (f_r <= rd.pos) ? rd.colour : c1_r;
        status_nxt = ST_OK;
        state_nxt  = S_IDLE;
      end
      S_LK_WALK: begin
        // f is below the last stop, so the walk stops at or before it
        if (f_r <= rd.pos) begin
          if (i_r == '0) begin
            strobe_nxt = 1'b1;
            rgb_nxt    = rd.colour;
            status_nxt = ST_OK;
            state_nxt  = S_IDLE;
          end else begin
            w0_nxt    = rd.pos - f_r;
            w1_nxt    = f_r - prev_r.pos;
            span_nxt  = rd.pos - prev_r.pos;
            c1_nxt    = rd.colour;
            state_nxt = S_LK_GO;
          end
        end else begin
          prev_nxt  = rd;
          i_nxt     = i_r + IDX_W'(1);
          ram_raddr = i_r + IDX_W'(1);
        end
      end
      S_LK_GO: begin
        lerp_go   = 1'b1;
        state_nxt = S_LK_WAIT;
      end
      S_LK_WAIT: begin
        if (lerp_done[0]) begin
          strobe_nxt = 1'b1;
          rgb_nxt    = {lerp_q[2], lerp_q[1], lerp_q[0]};
          status_nxt = ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rgb_r    <= rgb_nxt;
    status_r <= status_nxt;
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    f_r      <= f_nxt;
    new_r    <= new_nxt;
    prev_r   <= prev_nxt;
    w0_r     <= w0_nxt;
    w1_r     <= w1_nxt;
    span_r   <= span_nxt;
    c1_r     <= c1_nxt;
  end

  assign busy          = state_r != S_IDLE;
  assign out_strobe    = strobe_r;
  assign out_red_out   = rgb_r[23:16];
  assign out_green_out = rgb_r[15:8];
  assign out_blue_out  = rgb_r[7:0];
  assign out_status    = status_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_STOPS))
    else $error("stop count beyond table size");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_INSERT && count_r == CNT_W'(MAX_STOPS)
    |=> out_strobe && out_status == ST_FULL && count_r == CNT_W'(MAX_STOPS))
    else $error("insert into full table not dropped");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_done[0] |-> lerp_done == 3'b111)
    else $error("interpolation lanes out of step");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE || state_r == S_INS_CMP || state_r == S_INS_WR0)
    else $error("table write outside insert");

  a_lookup_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LK_WAIT && lerp_done[0] |=> out_strobe && out_status == ST_OK && !busy)
    else $error("interpolated lookup not delivered");

endmodule
